// ===== sv/fpa_pkg.sv =====
package fpa_pkg;

  localparam int DefFractionBits = 8;
  localparam int DataWidth = 32;
  localparam int QuoBits = 63;

  typedef enum logic [3:0] {
    ActAdd     = 4'd0,
    ActSub     = 4'd1,
    ActMul     = 4'd2,
    ActDiv     = 4'd3,
    ActMin     = 4'd4,
    ActMax     = 4'd5,
    ActCompare = 4'd6,
    ActInc     = 4'd7,
    ActDec     = 4'd8,
    ActToInt   = 4'd9,
    ActFromInt = 4'd10
  } action_e;

  typedef struct packed {
    logic        [3:0]  action;
    logic signed [31:0] operand_a;
    logic signed [31:0] operand_b;
  } in_word_t;

  typedef struct packed {
    logic signed [31:0] result;
    logic               greater;
    logic               less;
    logic               equal;
    logic               overflow;
    logic               divide_by_zero;
  } out_word_t;

  // Work carried from cell to cell of the divider chain.
  typedef struct packed {
    logic               vld;
    logic [3:0]         action;
    logic               neg;
    logic               dz;
    logic               a_zero;
    logic signed [31:0] fast_res;
    logic               fast_ovf;
    logic [63:0]        rem;
    logic [63:0]        num;
    logic [31:0]        den;
    logic [QuoBits-1:0] quo;
    logic               greater;
    logic               less;
    logic               equal;
  } cell_t;

endpackage

// ===== sv/fpa_cell.sv =====
module fpa_cell import fpa_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  en_i,
  input  cell_t cell_i,
  output cell_t cell_o
);

  cell_t cell_d, data_q;
  logic  vld_q;
  logic [64:0] trial;
  logic [63:0] shifted;

  // One restoring division step: one quotient bit per cell.
  always_comb begin
    cell_d = cell_i;
    shifted = {cell_i.rem[62:0], cell_i.num[63]};
    trial = {1'b0, shifted} - {33'd0, cell_i.den};
    cell_d.num = {cell_i.num[62:0], 1'b0};
    if (!trial[64]) begin
      cell_d.rem = trial[63:0];
      cell_d.quo = {cell_i.quo[QuoBits-2:0], 1'b1};
    end else begin
      cell_d.rem = shifted;
      cell_d.quo = {cell_i.quo[QuoBits-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (en_i) begin
      vld_q <= cell_d.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= cell_d;
    end
  end

  always_comb begin
    cell_o = data_q;
    cell_o.vld = vld_q;
  end

endmodule

// ===== sv/fpa_front.sv =====
module fpa_front import fpa_pkg::*; #(
  parameter int FractionBits = DefFractionBits
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     en_i,
  input  logic     valid_i,
  input  in_word_t word_i,
  output cell_t    cell_o
);

  localparam logic [63:0] Half =
    (FractionBits > 0) ? (64'd1 << (FractionBits - 1)) : 64'd0;
  localparam logic [32:0] RoundAdd = (33'd1 << FractionBits) - 33'd1;

  logic signed [32:0] a_x, b_x;
  logic [31:0] ma, mb;
  logic [31:0] ma_q, mb_q;
  logic        vld_q, sgn_q;
  logic [3:0]  act_q;
  logic signed [31:0] fres_q;
  logic        fovf_q, dz_q, az_q, g_q, l_q, e_q;
  logic [63:0] prod;
  logic [63:0] pr;
  logic signed [32:0] sum;
  logic signed [31:0] fres;
  logic        fovf;
  logic [63:0] sh;

  function automatic logic [32:0] sat_mag(input logic neg, input logic [63:0] m);
    logic [32:0] r;
    if (neg) begin
      if (m > 64'h8000_0000) r = {1'b1, 32'h8000_0000};
      else r = {1'b0, 32'd0 - m[31:0]};
    end else begin
      if (m > 64'h7FFF_FFFF) r = {1'b1, 32'h7FFF_FFFF};
      else r = {1'b0, m[31:0]};
    end
    return r;
  endfunction

  function automatic logic [32:0] sat_sum(input logic signed [32:0] v);
    logic [32:0] r;
    if (v > 33'sd2147483647) r = {1'b1, 32'h7FFF_FFFF};
    else if (v < -33'sd2147483648) r = {1'b1, 32'h8000_0000};
    else r = {1'b0, v[31:0]};
    return r;
  endfunction

  assign a_x = 33'(word_i.operand_a);
  assign b_x = 33'(word_i.operand_b);
  assign ma = word_i.operand_a[31] ? 32'd0 - word_i.operand_a : word_i.operand_a;
  assign mb = word_i.operand_b[31] ? 32'd0 - word_i.operand_b : word_i.operand_b;

  // Everything but the multiply and the division settles here; add and shift terms are narrow.
  always_comb begin
    logic [32:0] s;
    s = 33'd0;
    sum = 33'sd0;
    unique case (word_i.action)
      ActAdd:  sum = a_x + b_x;
      ActSub:  sum = a_x - b_x;
      ActInc:  sum = a_x + 33'sd1;
      ActDec:  sum = a_x - 33'sd1;
      default: sum = 33'sd0;
    endcase
    sh = {32'd0, ma} << FractionBits;
    unique case (word_i.action)
      ActAdd, ActSub, ActInc, ActDec: s = sat_sum(sum);
      ActMin: s = {1'b0, (a_x <= b_x) ? word_i.operand_a : word_i.operand_b};
      ActMax: s = {1'b0, (a_x >= b_x) ? word_i.operand_a : word_i.operand_b};
      ActToInt: begin
        if (word_i.operand_a[31])
          s = {1'b0, 32'd0 - 32'(({1'b0, ma} + RoundAdd) >> FractionBits)};
        else
          s = {1'b0, 32'(ma >> FractionBits)};
      end
      ActFromInt: s = sat_mag(word_i.operand_a[31], sh);
      default: s = 33'd0;
    endcase
    fres = s[31:0];
    fovf = s[32];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vld_q <= 1'b0;
    else if (en_i) vld_q <= valid_i;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      act_q  <= word_i.action;
      ma_q   <= ma;
      mb_q   <= mb;
      sgn_q  <= word_i.operand_a[31] ^ word_i.operand_b[31];
      fres_q <= fres;
      fovf_q <= fovf;
      dz_q   <= (word_i.operand_b == 32'sd0);
      az_q   <= (word_i.operand_a == 32'sd0);
      g_q    <= a_x > b_x;
      l_q    <= a_x < b_x;
      e_q    <= a_x == b_x;
    end
  end

  // Second half: the registered multiply, rounded, and the division setup.
  assign prod = ma_q * mb_q;
  assign pr = (prod + Half) >> FractionBits;

  always_comb begin
    logic [32:0] m;
    m = sat_mag(sgn_q, pr);
    cell_o = '0;
    cell_o.vld = vld_q;
    cell_o.action = act_q;
    cell_o.neg = sgn_q;
    cell_o.dz = dz_q;
    cell_o.a_zero = az_q;
    cell_o.fast_res = (act_q == ActMul) ? m[31:0] : fres_q;
    cell_o.fast_ovf = (act_q == ActMul) ? m[32] : fovf_q;
    // Dividend is 2*|a|*2^F + |b|, to be divided by 2*|b|. The chain only
    // steps through the upper 63 bits, which halves the dividend, so the
    // divisor it sees is |b|.
    cell_o.num = ({32'd0, ma_q} << (FractionBits + 1)) + {32'd0, mb_q};
    cell_o.den = mb_q;
    cell_o.greater = g_q;
    cell_o.less = l_q;
    cell_o.equal = e_q;
  end

endmodule

// ===== sv/fpa_back.sv =====
module fpa_back import fpa_pkg::*; (
  input  cell_t     cell_i,
  output out_word_t word_o
);

  logic [32:0] m;

  always_comb begin
    if (cell_i.neg) begin
      if (cell_i.quo > QuoBits'(64'h8000_0000)) m = {1'b1, 32'h8000_0000};
      else m = {1'b0, 32'd0 - cell_i.quo[31:0]};
    end else begin
      if (cell_i.quo > QuoBits'(64'h7FFF_FFFF)) m = {1'b1, 32'h7FFF_FFFF};
      else m = {1'b0, cell_i.quo[31:0]};
    end
    word_o.greater = cell_i.greater;
    word_o.less = cell_i.less;
    word_o.equal = cell_i.equal;
    word_o.divide_by_zero = 1'b0;
    if (cell_i.action == ActDiv) begin
      if (cell_i.dz) begin
        word_o.divide_by_zero = 1'b1;
        word_o.overflow = 1'b0;
        if (cell_i.a_zero) word_o.result = 32'sd0;
        else word_o.result = cell_i.neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
      end else begin
        word_o.result = m[31:0];
        word_o.overflow = m[32];
      end
    end else begin
      word_o.result = cell_i.fast_res;
      word_o.overflow = cell_i.fast_ovf;
    end
  end

endmodule

// ===== sv/fixed_point_alu_core.sv =====
// Channel | Direction | Handshake          | Word
// in      | input     | in_valid_i/in_stall_o   | in_word_t
// out     | output    | out_valid_o/out_stall_i | out_word_t
// One word is accepted every cycle while in is not stalled; each passes through
// the front register and then the divider chain of one restoring cell
// per quotient bit.
// Reset clears all valid bits. The whole chain holds while out is stalled
// with a word in the last cell; it otherwise advances every cycle.
module fixed_point_alu_core import fpa_pkg::*; #(
  parameter int FractionBits = DefFractionBits
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_word_t  in_word_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_word_t out_word_o
);

  cell_t chain [QuoBits+1];
  logic  en;

  assign en = !(chain[QuoBits].vld && out_stall_i);
  assign in_stall_o = !en;

  fpa_front #(.FractionBits(FractionBits)) u_front (
    .clk_i, .rst_ni, .en_i(en), .valid_i(in_valid_i),
    .word_i(in_word_i), .cell_o(chain[0])
  );

  for (genvar i = 0; i < QuoBits; i++) begin : g_cell
    fpa_cell u_cell (
      .clk_i, .rst_ni, .en_i(en), .cell_i(chain[i]), .cell_o(chain[i+1])
    );
  end

  fpa_back u_back (.cell_i(chain[QuoBits]), .word_o(out_word_o));

  assign out_valid_o = chain[QuoBits].vld;

endmodule
